/* rtl/fet_pkg.sv */
`default_nettype none

package fet_pkg;

	// Field widths of a request and of a response
	localparam int CMD_W    = 2;
	localparam int SLOT_W   = 4;
	localparam int CHUNK_W  = 10;
	localparam int COUNT_W  = 11;
	localparam int STATUS_W = 3;

	// Largest value the 11-bit running total may hold
	localparam int TOTAL_LIMIT = 2047;

	typedef enum logic [CMD_W-1:0] {
		CMD_ALLOC = 2'd0,
		CMD_FREE  = 2'd1,
		CMD_TRUNC = 2'd2,
		CMD_CHECK = 2'd3
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 3'd0,
		ST_FULL      = 3'd1,
		ST_INVALID   = 3'd2,
		ST_NOT_OWNED = 3'd3,
		ST_TRIM_LONG = 3'd4
	} status_t;

	// Controller to datapath commands
	typedef struct packed {
		logic load_in;   // capture the incoming request
		logic exec;      // apply the request to the table and load the response
	} ctrl_cmd_t;

endpackage

`default_nettype wire

/* rtl/fet_req_if.sv */
`default_nettype none

interface fet_req_if;
	logic                        valid;
	logic                        ready;
	logic [fet_pkg::CMD_W-1:0]   command;
	logic [fet_pkg::SLOT_W-1:0]  slot;
	logic [fet_pkg::CHUNK_W-1:0] chunk_index;
	logic [fet_pkg::COUNT_W-1:0] count;

	modport source(output valid, command, slot, chunk_index, count, input ready);
	modport sink(input valid, command, slot, chunk_index, count, output ready);
endinterface

`default_nettype wire

/* rtl/fet_rsp_if.sv */
`default_nettype none

interface fet_rsp_if;
	logic                         valid;
	logic                         ready;
	logic [fet_pkg::STATUS_W-1:0] status;
	logic [fet_pkg::SLOT_W-1:0]   result_slot;
	logic [fet_pkg::CHUNK_W-1:0]  release_start;
	logic [fet_pkg::COUNT_W-1:0]  release_count;
	logic [fet_pkg::COUNT_W-1:0]  allocated_now;

	modport source(output valid, status, result_slot, release_start, release_count,
		allocated_now, input ready);
	modport sink(input valid, status, result_slot, release_start, release_count,
		allocated_now, output ready);
endinterface

`default_nettype wire

/* rtl/file_extent_table.sv */
// Channel  Dir  Payload                                                   Handshake
// req      in   command, slot, chunk_index, count                          valid/ready
// rsp      out  status, result_slot, release_start, release_count,          valid/ready
//               allocated_now
//
// Each request is first captured, then applied in a parallel compare,
// shift and update of the extent cells, which also loads the response register.
// A new request is taken the cycle after the response is loaded, while it still waits.
// A stalled response holds the execute step of the following request.
// Reset clears the valid bits, the chunk total and the handshake state;
// extent base and length hold no reset value and are read only while valid.
`default_nettype none

module file_extent_table #(
	parameter int MAX_EXTENTS  = 16,
	parameter int TOTAL_CHUNKS = 1024
) (
	input  wire logic clk,
	input  wire logic arst_n,
	fet_req_if.sink   req,
	fet_rsp_if.source rsp
);

	fet_pkg::ctrl_cmd_t cmd;

	fet_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.cmd       (cmd)
	);

	fet_dpath #(
		.MAX_EXTENTS  (MAX_EXTENTS),
		.TOTAL_CHUNKS (TOTAL_CHUNKS)
	) u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.command       (req.command),
		.slot          (req.slot),
		.chunk_index   (req.chunk_index),
		.count         (req.count),
		.status        (rsp.status),
		.result_slot   (rsp.result_slot),
		.release_start (rsp.release_start),
		.release_count (rsp.release_count),
		.allocated_now (rsp.allocated_now)
	);

endmodule

`default_nettype wire

/* rtl/fet_ctrl.sv */
`default_nettype none

module fet_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               req_valid,
	output logic                    req_ready,
	output logic                    rsp_valid,
	input  wire logic               rsp_ready,
	output fet_pkg::ctrl_cmd_t      cmd
);

	typedef enum logic {
		S_IDLE,
		S_EXEC
	} state_t;

	state_t state_q;
	logic   ready_q;
	logic   out_valid_q;

	// Execute once the response register is free or being drained
	always_comb begin
		cmd.load_in = req_valid && ready_q;
		cmd.exec    = (state_q == S_EXEC) && (!out_valid_q || rsp_ready);
	end

	// State and registered handshake outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ready_q     <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			// response valid: set on execute, cleared once taken
			if (cmd.exec) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (cmd.load_in) begin
						state_q <= S_EXEC;
						ready_q <= 1'b0;
					end
				end
				S_EXEC: begin
					if (cmd.exec) begin
						state_q <= S_IDLE;
						ready_q <= 1'b1;
					end
				end
				default: begin
					state_q <= S_IDLE;
					ready_q <= 1'b1;
				end
			endcase
		end
	end

	assign req_ready = ready_q;
	assign rsp_valid = out_valid_q;

`ifndef SYNTHESIS
	a_load_to_exec: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_in |=> (state_q == S_EXEC) && !ready_q)
		else $error("request captured but controller not executing");

	a_exec_gives_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec |=> out_valid_q && ready_q)
		else $error("execute did not produce a response");

	a_rsp_held: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("response dropped before it was taken");
`endif

endmodule

`default_nettype wire

/* rtl/fet_dpath.sv */
`default_nettype none

module fet_dpath #(
	parameter int MAX_EXTENTS  = 16,
	parameter int TOTAL_CHUNKS = 1024
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire fet_pkg::ctrl_cmd_t            cmd,
	input  wire logic [fet_pkg::CMD_W-1:0]     command,
	input  wire logic [fet_pkg::SLOT_W-1:0]    slot,
	input  wire logic [fet_pkg::CHUNK_W-1:0]   chunk_index,
	input  wire logic [fet_pkg::COUNT_W-1:0]   count,
	output logic      [fet_pkg::STATUS_W-1:0]  status,
	output logic      [fet_pkg::SLOT_W-1:0]    result_slot,
	output logic      [fet_pkg::CHUNK_W-1:0]   release_start,
	output logic      [fet_pkg::COUNT_W-1:0]   release_count,
	output logic      [fet_pkg::COUNT_W-1:0]   allocated_now
);

	localparam int IDX_W     = $clog2(MAX_EXTENTS);
	localparam int CMP_W     = IDX_W + fet_pkg::SLOT_W + 1;
	localparam int RNG_W     = 18;
	localparam int END_W     = fet_pkg::COUNT_W + 1;
	localparam int TOTAL_CAP = (TOTAL_CHUNKS < fet_pkg::TOTAL_LIMIT) ?
		TOTAL_CHUNKS : fet_pkg::TOTAL_LIMIT;

	// Captured request
	fet_pkg::cmd_t                cmd_q;
	logic [fet_pkg::SLOT_W-1:0]   slot_q;
	logic [fet_pkg::CHUNK_W-1:0]  chunk_q;
	logic [fet_pkg::COUNT_W-1:0]  count_q;

	// Extent cells; valid slots always form a prefix
	logic [fet_pkg::CHUNK_W-1:0]  base_q [MAX_EXTENTS];
	logic [fet_pkg::COUNT_W-1:0]  len_q  [MAX_EXTENTS];
	logic [MAX_EXTENTS-1:0]       valid_q;
	logic [fet_pkg::COUNT_W-1:0]  total_q;

	// Response register
	fet_pkg::status_t             status_q;
	logic [fet_pkg::SLOT_W-1:0]   rslot_q;
	logic [fet_pkg::CHUNK_W-1:0]  rstart_q;
	logic [fet_pkg::COUNT_W-1:0]  rcount_q;
	logic [fet_pkg::COUNT_W-1:0]  now_q;

	logic [IDX_W-1:0]             free_idx;
	logic                         full;
	logic                         hit;
	logic [CMP_W-1:0]             slot_cmp;
	logic                         slot_ok;
	logic [IDX_W-1:0]             slot_idx;
	logic                         sel_valid;
	logic [fet_pkg::CHUNK_W-1:0]  sel_base;
	logic [fet_pkg::COUNT_W-1:0]  sel_len;
	logic [RNG_W-1:0]             alloc_end;
	logic                         do_alloc;
	logic                         do_remove;
	logic                         do_trim;
	logic [fet_pkg::COUNT_W-1:0]  sub_n;
	logic [END_W-1:0]             add_sum;
	logic [fet_pkg::COUNT_W-1:0]  total_next;
	fet_pkg::status_t             status_d;
	logic [fet_pkg::SLOT_W-1:0]   rslot_d;
	logic [fet_pkg::CHUNK_W-1:0]  rstart_d;
	logic [fet_pkg::COUNT_W-1:0]  rcount_d;

	// Request capture
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			cmd_q   <= fet_pkg::cmd_t'(command);
			slot_q  <= slot;
			chunk_q <= chunk_index;
			count_q <= count;
		end
	end

	// First free slot and parallel ownership compare over all cells
	always_comb begin
		free_idx = '0;
		full     = 1'b1;
		hit      = 1'b0;
		for (int i = MAX_EXTENTS - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_idx = IDX_W'(i);
				full     = 1'b0;
			end
		end
		for (int i = 0; i < MAX_EXTENTS; i++) begin
			if (valid_q[i] && (base_q[i] <= chunk_q) &&
				(END_W'(base_q[i]) + END_W'(len_q[i]) > END_W'(chunk_q))) begin
				hit = 1'b1;
			end
		end
	end

	// Addressed slot for free and truncate
	assign slot_cmp  = CMP_W'(slot_q);
	assign slot_ok   = slot_cmp < CMP_W'(MAX_EXTENTS);
	assign slot_idx  = slot_cmp[IDX_W-1:0];
	assign sel_valid = slot_ok && valid_q[slot_idx];
	assign sel_base  = base_q[slot_idx];
	assign sel_len   = len_q[slot_idx];
	assign alloc_end = RNG_W'(chunk_q) + RNG_W'(count_q);

	// Command decode and result
	always_comb begin
		status_d  = fet_pkg::ST_OK;
		rslot_d   = '0;
		rstart_d  = '0;
		rcount_d  = '0;
		do_alloc  = 1'b0;
		do_remove = 1'b0;
		do_trim   = 1'b0;
		sub_n     = '0;
		case (cmd_q)
			fet_pkg::CMD_ALLOC: begin
				if (full) begin
					status_d = fet_pkg::ST_FULL;
				end else if ((count_q == '0) || (alloc_end > RNG_W'(TOTAL_CHUNKS))) begin
					status_d = fet_pkg::ST_INVALID;
				end else begin
					do_alloc = 1'b1;
					rslot_d  = fet_pkg::SLOT_W'(free_idx);
				end
			end
			fet_pkg::CMD_FREE, fet_pkg::CMD_TRUNC: begin
				if (!sel_valid) begin
					status_d = fet_pkg::ST_INVALID;
				end else if ((cmd_q == fet_pkg::CMD_FREE) || (count_q == sel_len)) begin
					do_remove = 1'b1;
					rstart_d  = sel_base;
					rcount_d  = sel_len;
					sub_n     = sel_len;
				end else if (count_q > sel_len) begin
					status_d = fet_pkg::ST_TRIM_LONG;
				end else if (count_q != '0) begin
					do_trim  = 1'b1;
					rstart_d = fet_pkg::CHUNK_W'(END_W'(sel_base) + END_W'(sel_len)
						- END_W'(count_q));
					rcount_d = count_q;
					sub_n    = count_q;
				end
			end
			fet_pkg::CMD_CHECK: begin
				if (RNG_W'(chunk_q) >= RNG_W'(TOTAL_CHUNKS)) begin
					status_d = fet_pkg::ST_INVALID;
				end else if (!hit) begin
					status_d = fet_pkg::ST_NOT_OWNED;
				end
			end
			default: ;
		endcase
	end

	// Running total: saturating add, flooring subtract
	assign add_sum = END_W'(total_q) + END_W'(count_q);
	always_comb begin
		if (do_alloc) begin
			total_next = (add_sum > END_W'(TOTAL_CAP)) ? fet_pkg::COUNT_W'(TOTAL_CAP)
				: add_sum[fet_pkg::COUNT_W-1:0];
		end else if (sub_n > total_q) begin
			total_next = '0;
		end else begin
			total_next = total_q - sub_n;
		end
	end

	// Cell contents: fill, trim, shift left on removal
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			for (int i = 0; i < MAX_EXTENTS; i++) begin
				if (do_alloc && (free_idx == IDX_W'(i))) begin
					base_q[i] <= chunk_q;
					len_q[i]  <= count_q;
				end
				if (do_trim && (slot_idx == IDX_W'(i))) begin
					len_q[i] <= sel_len - count_q;
				end
				if (do_remove && (IDX_W'(i) >= slot_idx) && (i < MAX_EXTENTS - 1)) begin
					base_q[i] <= base_q[(i+1) % MAX_EXTENTS];
					len_q[i]  <= len_q[(i+1) % MAX_EXTENTS];
				end
			end
		end
	end

	// Valid bits and total
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			total_q <= '0;
		end else if (cmd.exec) begin
			total_q <= total_next;
			for (int i = 0; i < MAX_EXTENTS; i++) begin
				if (do_alloc && (free_idx == IDX_W'(i))) begin
					valid_q[i] <= 1'b1;
				end
				if (do_remove && (IDX_W'(i) >= slot_idx)) begin
					valid_q[i] <= (i < MAX_EXTENTS - 1) ? valid_q[(i+1) % MAX_EXTENTS] : 1'b0;
				end
			end
		end
	end

	// Response register
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			status_q <= status_d;
			rslot_q  <= rslot_d;
			rstart_q <= rstart_d;
			rcount_q <= rcount_d;
			now_q    <= total_next;
		end
	end

	assign status        = status_q;
	assign result_slot   = rslot_q;
	assign release_start = rstart_q;
	assign release_count = rcount_q;
	assign allocated_now = now_q;

`ifndef SYNTHESIS
	a_valid_prefix: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot({1'b0, valid_q} + {{MAX_EXTENTS{1'b0}}, 1'b1}))
		else $error("valid slots do not form a prefix");

	a_total_cap: assert property (@(posedge clk) disable iff (!arst_n)
		total_q <= fet_pkg::COUNT_W'(TOTAL_CAP))
		else $error("chunk total above its cap");

	a_empty_no_total: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q == '0) |-> (total_q == '0))
		else $error("empty table with chunks still counted");
`endif

endmodule

`default_nettype wire

/* tb/tb_file_extent_table.sv */
`timescale 1ns / 1ps

module tb_file_extent_table;

	localparam int EXTENT_SLOTS = 16;
	localparam int CHUNK_SPAN   = 1024;
	localparam int TOTAL_CAP    = (CHUNK_SPAN < fet_pkg::TOTAL_LIMIT) ? CHUNK_SPAN
		: fet_pkg::TOTAL_LIMIT;
	localparam int RANDOM_REQS  = 1000;
	localparam int CYCLE_LIMIT  = 400000;

	// One request to the table; hold_idle makes the sender wait until nothing is owed
	typedef struct {
		fet_pkg::cmd_t               command;
		logic [fet_pkg::SLOT_W-1:0]  slot;
		logic [fet_pkg::CHUNK_W-1:0] chunk_index;
		logic [fet_pkg::COUNT_W-1:0] count;
		bit                          hold_idle;
	} extent_req_t;

	typedef struct {
		fet_pkg::status_t            status;
		logic [fet_pkg::SLOT_W-1:0]  result_slot;
		logic [fet_pkg::CHUNK_W-1:0] release_start;
		logic [fet_pkg::COUNT_W-1:0] release_count;
		logic [fet_pkg::COUNT_W-1:0] allocated_now;
	} extent_rsp_t;

	logic clk;
	logic arst_n;

	fet_req_if req_if();
	fet_rsp_if rsp_if();

	file_extent_table #(
		.MAX_EXTENTS (EXTENT_SLOTS),
		.TOTAL_CHUNKS(CHUNK_SPAN)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_if),
		.rsp   (rsp_if)
	);

	// Shadow of the extent table
	logic [fet_pkg::CHUNK_W-1:0] shadow_base [EXTENT_SLOTS];
	logic [fet_pkg::COUNT_W-1:0] shadow_len  [EXTENT_SLOTS];
	bit                          shadow_used [EXTENT_SLOTS];
	int                          owned_chunks;

	extent_req_t pending_reqs[$];
	extent_rsp_t owed_rsps[$];

	extent_req_t next_req;
	extent_rsp_t oldest_rsp;
	int          send_gap;
	int          recv_stall;
	bit          send_steady;
	bit          recv_steady;
	int          mismatch_count;
	int          cycle_count;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Apply one request to the shadow table and return the response it must produce
	function automatic extent_rsp_t apply_extent_cmd(fet_pkg::cmd_t cmd,
		logic [fet_pkg::SLOT_W-1:0] slot, logic [fet_pkg::CHUNK_W-1:0] chunk,
		logic [fet_pkg::COUNT_W-1:0] count);
		extent_rsp_t rsp;
		int          free_idx;
		int          base_v;
		int          len_v;
		int          k;
		bit          searching;
		rsp.status        = fet_pkg::ST_OK;
		rsp.result_slot   = '0;
		rsp.release_start = '0;
		rsp.release_count = '0;
		case (cmd)
			fet_pkg::CMD_ALLOC: begin
				free_idx = EXTENT_SLOTS;
				for (k = EXTENT_SLOTS - 1; k >= 0; k--)
					if (!shadow_used[k])
						free_idx = k;
				if (free_idx == EXTENT_SLOTS) begin
					rsp.status = fet_pkg::ST_FULL;
				end else if (count == 0 || int'(chunk) + int'(count) > CHUNK_SPAN) begin
					rsp.status = fet_pkg::ST_INVALID;
				end else begin
					shadow_used[free_idx] = 1'b1;
					shadow_base[free_idx] = chunk;
					shadow_len[free_idx]  = count;
					owned_chunks = owned_chunks + int'(count);
					if (owned_chunks > TOTAL_CAP)
						owned_chunks = TOTAL_CAP;
					rsp.result_slot = fet_pkg::SLOT_W'(free_idx);
				end
			end
			fet_pkg::CMD_FREE, fet_pkg::CMD_TRUNC: begin
				if (int'(slot) >= EXTENT_SLOTS || !shadow_used[slot]) begin
					rsp.status = fet_pkg::ST_INVALID;
				end else begin
					base_v = int'(shadow_base[slot]);
					len_v  = int'(shadow_len[slot]);
					if (cmd == fet_pkg::CMD_FREE || int'(count) == len_v) begin
						// whole extent goes back; later slots close the hole
						rsp.release_start = fet_pkg::CHUNK_W'(base_v);
						rsp.release_count = fet_pkg::COUNT_W'(len_v);
						owned_chunks = (len_v > owned_chunks) ? 0 : owned_chunks - len_v;
						for (k = int'(slot); k < EXTENT_SLOTS - 1; k++) begin
							shadow_base[k] = shadow_base[k + 1];
							shadow_len[k]  = shadow_len[k + 1];
							shadow_used[k] = shadow_used[k + 1];
						end
						shadow_base[EXTENT_SLOTS - 1] = '0;
						shadow_len[EXTENT_SLOTS - 1]  = '0;
						shadow_used[EXTENT_SLOTS - 1] = 1'b0;
					end else if (int'(count) > len_v) begin
						rsp.status = fet_pkg::ST_TRIM_LONG;
					end else if (count != 0) begin
						rsp.release_start = fet_pkg::CHUNK_W'(base_v + len_v - int'(count));
						rsp.release_count = count;
						shadow_len[slot]  = fet_pkg::COUNT_W'(len_v - int'(count));
						owned_chunks = (int'(count) > owned_chunks) ? 0
							: owned_chunks - int'(count);
					end
				end
			end
			default: begin
				if (int'(chunk) >= CHUNK_SPAN) begin
					rsp.status = fet_pkg::ST_INVALID;
				end else begin
					// search runs over the valid prefix only
					rsp.status = fet_pkg::ST_NOT_OWNED;
					searching  = 1'b1;
					for (k = 0; k < EXTENT_SLOTS; k++) begin
						if (searching && !shadow_used[k])
							searching = 1'b0;
						if (searching && int'(shadow_base[k]) <= int'(chunk)
							&& int'(shadow_base[k]) + int'(shadow_len[k]) > int'(chunk)) begin
							rsp.status = fet_pkg::ST_OK;
							searching  = 1'b0;
						end
					end
				end
			end
		endcase
		rsp.allocated_now = fet_pkg::COUNT_W'(owned_chunks);
		return rsp;
	endfunction

	function automatic void queue_req(fet_pkg::cmd_t cmd, int slot, int chunk, int count);
		extent_req_t r;
		r.command     = cmd;
		r.slot        = fet_pkg::SLOT_W'(slot);
		r.chunk_index = fet_pkg::CHUNK_W'(chunk);
		r.count       = fet_pkg::COUNT_W'(count);
		r.hold_idle   = 1'b0;
		pending_reqs.push_back(r);
	endfunction

	// Random request; fill phases favor allocate, drain phases favor free and truncate
	function automatic extent_req_t random_req(bit filling);
		extent_req_t r;
		int unsigned pick;
		int unsigned cnt;
		int unsigned chk;
		pick = $urandom_range(0, 99);
		if (filling)
			r.command = (pick < 55) ? fet_pkg::CMD_ALLOC : (pick < 70) ? fet_pkg::CMD_TRUNC
				: (pick < 80) ? fet_pkg::CMD_FREE : fet_pkg::CMD_CHECK;
		else
			r.command = (pick < 15) ? fet_pkg::CMD_ALLOC : (pick < 45) ? fet_pkg::CMD_TRUNC
				: (pick < 80) ? fet_pkg::CMD_FREE : fet_pkg::CMD_CHECK;
		// fields a command ignores still carry noise
		r.slot      = fet_pkg::SLOT_W'($urandom_range(0, 15));
		cnt         = $urandom_range(0, CHUNK_SPAN);
		chk         = $urandom_range(0, CHUNK_SPAN - 1);
		r.hold_idle = 1'b0;
		pick = $urandom_range(0, 99);
		case (r.command)
			fet_pkg::CMD_ALLOC: begin
				if (pick < 5) begin
					cnt = 0;
				end else if (pick < 10) begin
					cnt = $urandom_range(2, CHUNK_SPAN);
					chk = $urandom_range(CHUNK_SPAN + 1 - cnt, CHUNK_SPAN - 1);
				end else if (pick < 14) begin
					cnt = $urandom_range(256, CHUNK_SPAN);
					chk = $urandom_range(0, CHUNK_SPAN - cnt);
				end else begin
					cnt = $urandom_range(1, 40);
					chk = ($urandom_range(0, 3) == 0) ? $urandom_range(0, CHUNK_SPAN - cnt)
						: $urandom_range(0, 200);
				end
			end
			fet_pkg::CMD_FREE, fet_pkg::CMD_TRUNC: begin
				if ($urandom_range(0, 9) < 7)
					r.slot = fet_pkg::SLOT_W'($urandom_range(0, 5));
				if (pick < 50)
					cnt = $urandom_range(0, 6);
				else if (pick < 75)
					cnt = $urandom_range(0, 40);
				else if (pick < 85)
					cnt = CHUNK_SPAN;
			end
			default: begin
				if (pick < 60)
					chk = $urandom_range(0, 260);
			end
		endcase
		r.chunk_index = fet_pkg::CHUNK_W'(chk);
		r.count       = fet_pkg::COUNT_W'(cnt);
		return r;
	endfunction

	// Idle length: mostly none or short, now and then long; none at all in a steady stretch
	function automatic int idle_len(bit steady);
		int unsigned w;
		if (steady)
			return 0;
		w = $urandom_range(0, 99);
		if (w < 60)
			return 0;
		if (w < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatch_count++;
		end
	endtask

	// Request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_if.valid <= 1'b0;
			send_gap     <= 0;
			send_steady  <= 1'b0;
		end else begin
			if (req_if.valid && req_if.ready)
				owed_rsps.push_back(apply_extent_cmd(fet_pkg::cmd_t'(req_if.command),
					req_if.slot, req_if.chunk_index, req_if.count));
			if ($urandom_range(0, 199) == 0)
				send_steady <= !send_steady;
			// an offered request stays put until it is taken
			if (!req_if.valid || req_if.ready) begin
				if (send_gap != 0) begin
					send_gap     <= send_gap - 1;
					req_if.valid <= 1'b0;
				end else if (pending_reqs.size() != 0
					&& !(pending_reqs[0].hold_idle && owed_rsps.size() != 0)) begin
					next_req           = pending_reqs.pop_front();
					req_if.valid       <= 1'b1;
					req_if.command     <= next_req.command;
					req_if.slot        <= next_req.slot;
					req_if.chunk_index <= next_req.chunk_index;
					req_if.count       <= next_req.count;
					send_gap           <= idle_len(send_steady);
				end else begin
					req_if.valid <= 1'b0;
				end
			end
		end
	end

	// Response monitor and ready stalls
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_if.ready <= 1'b0;
			recv_stall   <= 0;
			recv_steady  <= 1'b0;
		end else begin
			if (rsp_if.valid && rsp_if.ready) begin
				if (owed_rsps.size() == 0) begin
					$error("response with none outstanding: status %0d", rsp_if.status);
					mismatch_count++;
				end else begin
					oldest_rsp = owed_rsps.pop_front();
					check_field("status", oldest_rsp.status, rsp_if.status);
					check_field("result_slot", oldest_rsp.result_slot, rsp_if.result_slot);
					check_field("release_start", oldest_rsp.release_start, rsp_if.release_start);
					check_field("release_count", oldest_rsp.release_count, rsp_if.release_count);
					check_field("allocated_now", oldest_rsp.allocated_now, rsp_if.allocated_now);
				end
			end
			if ($urandom_range(0, 199) == 0)
				recv_steady <= !recv_steady;
			if (recv_stall != 0) begin
				recv_stall   <= recv_stall - 1;
				rsp_if.ready <= 1'b0;
			end else begin
				rsp_if.ready <= 1'b1;
				recv_stall   <= idle_len(recv_steady);
			end
		end
	end

	// Watchdog
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Regression FAIL");
		$finish;
	end

	initial begin
		int          n;
		extent_req_t r;
		arst_n             = 1'b0;
		req_if.valid       = 1'b0;
		req_if.command     = fet_pkg::CMD_ALLOC;
		req_if.slot        = '0;
		req_if.chunk_index = '0;
		req_if.count       = '0;
		rsp_if.ready       = 1'b0;
		mismatch_count     = 0;
		owned_chunks       = 0;
		for (n = 0; n < EXTENT_SLOTS; n++) begin
			shadow_used[n] = 1'b0;
			shadow_base[n] = '0;
			shadow_len[n]  = '0;
		end

		// empty table: check stops at slot 0, free and truncate see empty slots
		queue_req(fet_pkg::CMD_CHECK, 0, 0, 0);
		queue_req(fet_pkg::CMD_FREE, 0, 0, 0);
		queue_req(fet_pkg::CMD_TRUNC, 15, 0, 1);
		// bad allocate: zero count, range past the end
		queue_req(fet_pkg::CMD_ALLOC, 0, 5, 0);
		queue_req(fet_pkg::CMD_ALLOC, 0, 1023, 2);
		// fill every slot with overlapping extents; the total saturates
		for (n = 0; n < EXTENT_SLOTS; n++)
			queue_req(fet_pkg::CMD_ALLOC, 0, n * 64, CHUNK_SPAN - n * 64);
		queue_req(fet_pkg::CMD_ALLOC, 0, 0, 1);
		queue_req(fet_pkg::CMD_CHECK, 0, 1023, 0);
		// last slot: trim too long, trim nothing, partial trim, trim to empty
		queue_req(fet_pkg::CMD_TRUNC, 15, 0, CHUNK_SPAN);
		queue_req(fet_pkg::CMD_TRUNC, 15, 0, 0);
		queue_req(fet_pkg::CMD_TRUNC, 15, 0, 63);
		queue_req(fet_pkg::CMD_TRUNC, 15, 0, 1);
		// free the full-span slot: total floors at zero, slots shift left
		queue_req(fet_pkg::CMD_FREE, 0, 0, 0);
		queue_req(fet_pkg::CMD_CHECK, 0, 0, 0);

		for (n = 0; n < RANDOM_REQS; n++) begin
			r = random_req(((n / 60) % 2) == 0);
			r.hold_idle = (n % 250 == 0);
			pending_reqs.push_back(r);
		end

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_reqs.size() != 0 || req_if.valid)
			@(posedge clk);
		while (owed_rsps.size() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);

		if (mismatch_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

/* files.f */
rtl/fet_pkg.sv
rtl/fet_req_if.sv
rtl/fet_rsp_if.sv
rtl/fet_ctrl.sv
rtl/fet_dpath.sv
rtl/file_extent_table.sv
tb/tb_file_extent_table.sv
